FILE: hw/rtl/ihs_pkg.sv
// Shared types and constants for the image header sniffer.
// No dependencies; used by ihs_track, ihs_decode and image_header_sniffer_top.
`default_nettype none

package ihs_pkg;

    localparam int POSITION_BITS = 24;
    localparam int HDR_DEPTH     = 30;
    localparam int FRAME_BYTES   = 4;

    typedef logic [POSITION_BITS-1:0] pos_t;

    // Saturation point of the byte position counter
    localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

    // Image formats reported in image_type
    typedef enum logic [2:0] {
        IMG_UNKNOWN = 3'd0,
        IMG_PNG     = 3'd1,
        IMG_JPEG    = 3'd2,
        IMG_BMP     = 3'd3,
        IMG_WEBP    = 3'd4
    } img_type_t;

    localparam logic [7:0] PNG_MAGIC [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic [7:0] JPEG_MARK_PREFIX = 8'hFF;
    localparam logic [7:0] JPEG_SOI_CODE    = 8'hD8;
    localparam logic [7:0] JPEG_SOF0_CODE   = 8'hC0;
    localparam logic [7:0] JPEG_SOF2_CODE   = 8'hC2;
    localparam logic [7:0] BMP_MAGIC_0      = 8'h42;
    localparam logic [7:0] BMP_MAGIC_1      = 8'h4D;
    localparam logic [31:0] VP8_DIM_MASK    = 32'h0000_3FFF;

    // State seen by the decoder, with the current byte already merged into hdr
    typedef struct packed {
        logic [HDR_DEPTH-1:0][7:0]   hdr;
        pos_t                        idx;
        logic                        marker_seen;
        pos_t                        marker_offset;
        logic [FRAME_BYTES-1:0][7:0] frame;
    } hdr_view_t;

    typedef struct packed {
        logic [31:0] height;
        logic [31:0] width;
        img_type_t   kind;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ihs_track.sv
// Per-byte state of the sniffer: position, header bytes, JPEG SOF tracking.
// Depends on ihs_pkg.
`default_nettype none

module ihs_track (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    output ihs_pkg::hdr_view_t     view
);

    ihs_pkg::pos_t                                 pos_reg;
    logic [7:0]                                    prior_reg;
    logic                                          seen_reg;
    ihs_pkg::pos_t                                 offset_reg;
    logic [ihs_pkg::HDR_DEPTH-1:0][7:0]            hdr_reg;
    logic [ihs_pkg::FRAME_BYTES-1:0][7:0]          frame_reg;

    logic          sof_hit;
    ihs_pkg::pos_t sof_dist;
    logic          frame_wr;
    logic [1:0]    frame_sel;

    assign sof_hit = !seen_reg && (pos_reg >= ihs_pkg::pos_t'(3))
                     && (prior_reg == ihs_pkg::JPEG_MARK_PREFIX)
                     && ((data_byte == ihs_pkg::JPEG_SOF0_CODE)
                         || (data_byte == ihs_pkg::JPEG_SOF2_CODE));

    // distance from the SOF marker; frame size bytes sit at +5..+8
    assign sof_dist  = pos_reg - offset_reg;
    assign frame_wr  = seen_reg && (pos_reg >= offset_reg)
                       && (sof_dist >= ihs_pkg::pos_t'(5)) && (sof_dist <= ihs_pkg::pos_t'(8));
    // +5..+8 map to slots 0..3
    assign frame_sel = sof_dist[1:0] - 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            prior_reg  <= '0;
            seen_reg   <= 1'b0;
            offset_reg <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                prior_reg  <= '0;
                seen_reg   <= 1'b0;
                offset_reg <= '0;
            end
            else
            begin
                prior_reg <= data_byte;
                if (pos_reg != ihs_pkg::POS_MAX)
                begin
                    pos_reg <= pos_reg + ihs_pkg::pos_t'(1);
                end
                if (sof_hit)
                begin
                    seen_reg   <= 1'b1;
                    offset_reg <= pos_reg - ihs_pkg::pos_t'(1);
                end
            end
        end
    end

    // payload stores, no reset
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ihs_pkg::HDR_DEPTH; k++)
        begin
            if (step && (pos_reg == ihs_pkg::pos_t'(k)))
            begin
                hdr_reg[k] <= data_byte;
            end
        end
        if (step && frame_wr)
        begin
            frame_reg[frame_sel] <= data_byte;
        end
    end

    always_comb
    begin
        for (int k = 0; k < ihs_pkg::HDR_DEPTH; k++)
        begin
            view.hdr[k] = (pos_reg == ihs_pkg::pos_t'(k)) ? data_byte : hdr_reg[k];
        end
        view.idx           = pos_reg;
        view.marker_seen   = seen_reg;
        view.marker_offset = offset_reg;
        view.frame         = frame_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ihs_decode.sv
// Format and dimension decode from the captured header view.
// Depends on ihs_pkg.
`default_nettype none

module ihs_decode (
    input  wire ihs_pkg::hdr_view_t view,
    output ihs_pkg::result_t        result
);

    logic          is_png;
    logic          is_jpeg;
    logic          is_bmp;
    logic          is_webp;
    logic          is_vp8;
    logic          is_vp8l;
    logic          jpeg_ok;
    logic [31:0]   bmp_h;
    logic [31:0]   vp8l_bits;
    logic [ihs_pkg::POSITION_BITS:0] off_ext;

    function automatic logic [31:0] le32(input logic [ihs_pkg::HDR_DEPTH-1:0][7:0] h,
                                         input int at);
        le32 = {h[at+3], h[at+2], h[at+1], h[at]};
    endfunction

    function automatic logic [31:0] be32(input logic [ihs_pkg::HDR_DEPTH-1:0][7:0] h,
                                         input int at);
        be32 = {h[at], h[at+1], h[at+2], h[at+3]};
    endfunction

    always_comb
    begin
        is_png = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            if (view.hdr[k] != ihs_pkg::PNG_MAGIC[k])
            begin
                is_png = 1'b0;
            end
        end
    end

    assign is_jpeg = (view.hdr[0] == ihs_pkg::JPEG_MARK_PREFIX)
                     && (view.hdr[1] == ihs_pkg::JPEG_SOI_CODE)
                     && (view.hdr[2] == ihs_pkg::JPEG_MARK_PREFIX);
    assign is_bmp  = (view.hdr[0] == ihs_pkg::BMP_MAGIC_0) && (view.hdr[1] == ihs_pkg::BMP_MAGIC_1);
    assign is_webp = (view.idx >= ihs_pkg::pos_t'(11))
                     && ({view.hdr[3], view.hdr[2], view.hdr[1], view.hdr[0]} == "FFIR")
                     && ({view.hdr[11], view.hdr[10], view.hdr[9], view.hdr[8]} == "PBEW");
    assign is_vp8  = ({view.hdr[15], view.hdr[14], view.hdr[13], view.hdr[12]} == " 8PV");
    assign is_vp8l = ({view.hdr[15], view.hdr[14], view.hdr[13], view.hdr[12]} == "L8PV");

    // size = idx + 1, so offset + 10 <= size  <=>  offset + 9 <= idx
    assign off_ext = {1'b0, view.marker_offset} + (ihs_pkg::POSITION_BITS + 1)'(9);
    assign jpeg_ok = view.marker_seen && (off_ext <= {1'b0, view.idx});

    assign bmp_h     = le32(view.hdr, 22);
    assign vp8l_bits = le32(view.hdr, 21);

    always_comb
    begin
        result.kind   = ihs_pkg::IMG_UNKNOWN;
        result.width  = '0;
        result.height = '0;
        if (view.idx >= ihs_pkg::pos_t'(7))
        begin
            if (is_png)
            begin
                result.kind = ihs_pkg::IMG_PNG;
                if (view.idx >= ihs_pkg::pos_t'(23))
                begin
                    result.width  = be32(view.hdr, 16);
                    result.height = be32(view.hdr, 20);
                end
            end
            else if (is_jpeg)
            begin
                result.kind = ihs_pkg::IMG_JPEG;
                if (jpeg_ok)
                begin
                    result.height = {16'h0, view.frame[0], view.frame[1]};
                    result.width  = {16'h0, view.frame[2], view.frame[3]};
                end
            end
            else if (is_bmp)
            begin
                result.kind = ihs_pkg::IMG_BMP;
                if (view.idx >= ihs_pkg::pos_t'(25))
                begin
                    result.width  = le32(view.hdr, 18);
                    result.height = bmp_h[31] ? (~bmp_h + 32'd1) : bmp_h;
                end
            end
            else if (is_webp)
            begin
                result.kind = ihs_pkg::IMG_WEBP;
                if (view.idx >= ihs_pkg::pos_t'(29))
                begin
                    if (is_vp8)
                    begin
                        result.width  = {16'h0, view.hdr[27], view.hdr[26]}
                                        & ihs_pkg::VP8_DIM_MASK;
                        result.height = {16'h0, view.hdr[29], view.hdr[28]}
                                        & ihs_pkg::VP8_DIM_MASK;
                    end
                    else if (is_vp8l)
                    begin
                        result.width  = (vp8l_bits & ihs_pkg::VP8_DIM_MASK) + 32'd1;
                        result.height = ((vp8l_bits >> 14) & ihs_pkg::VP8_DIM_MASK) + 32'd1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/image_header_sniffer_top.sv
// Top level of the image header sniffer: input register, tracker, decoder, result register.
// Depends on ihs_pkg, ihs_track and ihs_decode.
`default_nettype none

// Image header sniffer. Bytes of an image file arrive one per transfer on the
// s_axis side, with s_axis_tlast on the final byte. On that byte one result
// transfer leaves on m_axis: the format (unknown, PNG, JPEG, BMP, WebP) and the
// width and height taken from the header, or zero where the file is too short
// or the header is not recognised. Files under 8 bytes report unknown. JPEG
// dimensions come from the first SOF0/SOF2 marker at offset 2 or later. The
// position and marker state clears after the last byte, so the next transfer
// starts a new file. Throughput is one byte per clock: a byte goes through an
// input register and then combinational compare logic into the tracking state,
// and the result of a final byte is captured in an output register, which drives
// m_axis_tvalid once the result slot is free. Non-final bytes keep flowing while
// a result waits to be taken; only a second final byte stalls until the pending
// result has left. The byte position saturates at 2^24 - 1.
module image_header_sniffer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input bytes
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // results
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [71:0] m_axis_tdata    // [2:0] image_type, [34:3] image_width,
                                             // [66:35] image_height, [71:67] zero
);

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    ihs_pkg::result_t  out_data_reg;

    logic               out_free;
    logic               step;
    ihs_pkg::hdr_view_t view;
    ihs_pkg::result_t   result;

    // a final byte needs the result slot; other bytes always move on
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step && in_last_reg)
        begin
            out_data_reg <= result;
        end
    end

    ihs_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .view      (view)
    );

    ihs_decode u_decode (
        .view   (view),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg.height, out_data_reg.width, out_data_reg.kind};

endmodule

`default_nettype wire
